// ===== hw/rtl/kdlp_pkg.sv =====
// Package with shared types and constants for the key debounce / long press block
package kdlp_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgW-1:0] DebounceReset  = 16'd20;
    localparam logic [CfgW-1:0] LongPressReset = 16'd600;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEBOUNCE_TIME   = 1'b0,
        REG_LONG_PRESS_TIME = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EV_NONE         = 2'd0,
        EV_SHORT_PRESS  = 2'd1,
        EV_LONG_START   = 2'd2,
        EV_LONG_RELEASE = 2'd3
    } t_key_event;

    typedef struct packed {
        t_key_event key_event;
        logic       stable_pressed;
    } t_result;

endpackage

// ===== hw/rtl/kdlp_core.sv =====
// Debounce and press classification state with single-pass next-state logic
module kdlp_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kdlp_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [kdlp_pkg::CfgW-1:0]          i_cfg_data,
    input  logic                               i_fire,
    input  logic                               i_raw_pressed,
    input  logic [kdlp_pkg::TimeW-1:0]         i_now_ms,
    output kdlp_pkg::t_result                  o_result
);

    logic [kdlp_pkg::CfgW-1:0]     r_debounce_time;
    logic [kdlp_pkg::CfgW-1:0]     r_long_press_time;
    logic                          r_last_raw;
    logic                          r_stable;
    logic [kdlp_pkg::TimeW-1:0]    r_change_time;
    logic [kdlp_pkg::TimeW-1:0]    r_press_time;
    logic                          r_long_mode;

    logic                          n_last_raw;
    logic                          n_stable;
    logic [kdlp_pkg::TimeW-1:0]    n_change_time;
    logic [kdlp_pkg::TimeW-1:0]    n_press_time;
    logic                          n_long_mode;
    logic [kdlp_pkg::TimeW-1:0]    held_ms;
    logic [kdlp_pkg::TimeW-1:0]    pressed_ms;
    kdlp_pkg::t_key_event          event_code;

    // Hold configuration registers; ignore indexes outside the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= kdlp_pkg::DebounceReset;
            r_long_press_time <= kdlp_pkg::LongPressReset;
        end else if (i_cfg_we) begin
            unique case (kdlp_pkg::t_cfg_reg'(i_cfg_idx))
                kdlp_pkg::REG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg_data;
                kdlp_pkg::REG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Restart the debounce timer on a raw change, then promote a held level
    always_comb begin
        n_last_raw    = i_raw_pressed;
        n_change_time = (i_raw_pressed != r_last_raw) ? i_now_ms : r_change_time;
        n_stable      = r_stable;
        n_press_time  = r_press_time;
        n_long_mode   = r_long_mode;
        event_code    = kdlp_pkg::EV_NONE;
        held_ms       = i_now_ms - n_change_time;

        if ((i_raw_pressed != r_stable) && (held_ms >= {16'd0, r_debounce_time})) begin
            n_stable = i_raw_pressed;
            if (i_raw_pressed) begin
                n_press_time = i_now_ms;
                n_long_mode  = 1'b0;
            end else begin
                event_code = r_long_mode ? kdlp_pkg::EV_LONG_RELEASE
                                         : kdlp_pkg::EV_SHORT_PRESS;
            end
        end

        // Report long-start once the threshold passes while pressed
        pressed_ms = i_now_ms - n_press_time;
        if (n_stable && !n_long_mode && (pressed_ms >= {16'd0, r_long_press_time})) begin
            n_long_mode = 1'b1;
            event_code  = kdlp_pkg::EV_LONG_START;
        end
    end

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
            r_long_mode   <= 1'b0;
        end else if (i_fire) begin
            r_last_raw    <= n_last_raw;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
            r_long_mode   <= n_long_mode;
        end
    end

    assign o_result.key_event      = event_code;
    assign o_result.stable_pressed = n_stable;

endmodule

// ===== hw/rtl/key_debounce_long_press.sv =====
// Top level: polled key debouncer with short / long press events
// An accepted result loads the output register, or the skid register on a stall.
// Throughput: one transaction per cycle while o_stall is low; the state update is
// a single pass through two 32-bit subtract-and-compare paths.
// A skid register stalls the input only when both output slots are full.
// Reset (synchronous, active low) restores register defaults and a released key at time 0.
module key_debounce_long_press (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kdlp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [kdlp_pkg::CfgW-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_raw_pressed,
    input  logic [kdlp_pkg::TimeW-1:0]    i_now_ms,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_key_event,
    output logic                          o_stable_pressed
);

    kdlp_pkg::t_result r_out;
    kdlp_pkg::t_result r_skid;
    kdlp_pkg::t_result result;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              in_fire;
    logic              out_free;

    assign in_fire  = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    kdlp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_fire        (in_fire),
        .i_raw_pressed (i_raw_pressed),
        .i_now_ms      (i_now_ms),
        .o_result      (result)
    );

    // Track occupancy of the output and skid slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Load result payloads; drain skid first to keep order
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= result;
            end
        end else if (in_fire) begin
            r_skid <= result;
        end
    end

    assign o_stall          = r_skid_valid;
    assign o_valid          = r_out_valid;
    assign o_key_event      = r_out.key_event;
    assign o_stable_pressed = r_out.stable_pressed;

endmodule

// ===== hw/rtl/kdlp_checker.sv =====
// Port-level checker for the key debounce / long press block, with its bind
module kdlp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_key_event,
    input logic       o_stable_pressed
);

    // Long-start only while the key is stably pressed
    a_long_start_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_event == kdlp_pkg::EV_LONG_START) |-> o_stable_pressed)
        else $error("long-start reported with key released");

    // Release events only with the key stably released
    a_release_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_key_event == kdlp_pkg::EV_SHORT_PRESS ||
                     o_key_event == kdlp_pkg::EV_LONG_RELEASE)) |-> !o_stable_pressed)
        else $error("release event reported with key pressed");

    // Accepted transaction into an empty output shows up next cycle
    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid) |=> o_valid)
        else $error("accepted transaction did not reach output");

    // Reset empties both channels
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output or stall active after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_key_event) && $stable(o_stable_pressed)))
        else $error("stalled result changed");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_key_event      (o_key_event),
    .o_stable_pressed (o_stable_pressed)
);
